FILE: hdl/rfpcr_pkg.sv
package rfpcr_pkg;

    localparam int CODE_BITS  = 32;
    localparam int POS_W      = $clog2(CODE_BITS);
    localparam int EDGE_CAP   = 4 * CODE_BITS + 1;
    localparam int EDGE_IDX_W = $clog2(EDGE_CAP + 1);
    localparam int HDR_EDGES  = 4;
    localparam int TIME_W     = 63;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 3'd6;

    localparam logic [WIN_W-1:0] RST_SYNC_MIN  = 16'd10000;
    localparam logic [WIN_W-1:0] RST_START_MIN = 16'd2600;
    localparam logic [WIN_W-1:0] RST_START_MAX = 16'd2800;
    localparam logic [WIN_W-1:0] RST_LONG_MIN  = 16'd1200;
    localparam logic [WIN_W-1:0] RST_LONG_MAX  = 16'd1400;
    localparam logic [WIN_W-1:0] RST_SHORT_MIN = 16'd190;
    localparam logic [WIN_W-1:0] RST_SHORT_MAX = 16'd330;

    // expected line level of header edges 0..3, bit n for edge n
    localparam logic [HDR_EDGES-1:0] HDR_LEVELS = 4'b0101;

    typedef enum logic [2:0] {
        GAP_NONE,
        GAP_SYNC,
        GAP_START,
        GAP_LONG,
        GAP_SHORT
    } t_gap;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              line_level;
    } t_in_item;

    typedef struct packed {
        logic        frame_ok;
        logic [31:0] frame_code;
    } t_out_item;

    typedef struct packed {
        logic [WIN_W-1:0] sync_min_us;
        logic [WIN_W-1:0] start_min_us;
        logic [WIN_W-1:0] start_max_us;
        logic [WIN_W-1:0] long_min_us;
        logic [WIN_W-1:0] long_max_us;
        logic [WIN_W-1:0] short_min_us;
        logic [WIN_W-1:0] short_max_us;
    } t_cfg;

    function automatic t_gap header_class(input logic [1:0] idx);
        t_gap cls;
        unique case (idx)
            2'd0:    cls = GAP_SYNC;
            2'd1:    cls = GAP_SHORT;
            2'd2:    cls = GAP_START;
            default: cls = GAP_SHORT;
        endcase
        return cls;
    endfunction

endpackage

FILE: hdl/rfpcr_cfg_regs.sv
module rfpcr_cfg_regs
    import rfpcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [WIN_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min_us  <= RST_SYNC_MIN;
            r_cfg.start_min_us <= RST_START_MIN;
            r_cfg.start_max_us <= RST_START_MAX;
            r_cfg.long_min_us  <= RST_LONG_MIN;
            r_cfg.long_max_us  <= RST_LONG_MAX;
            r_cfg.short_min_us <= RST_SHORT_MIN;
            r_cfg.short_max_us <= RST_SHORT_MAX;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_SYNC_MIN:  r_cfg.sync_min_us  <= i_data;
                CFG_START_MIN: r_cfg.start_min_us <= i_data;
                CFG_START_MAX: r_cfg.start_max_us <= i_data;
                CFG_LONG_MIN:  r_cfg.long_min_us  <= i_data;
                CFG_LONG_MAX:  r_cfg.long_max_us  <= i_data;
                CFG_SHORT_MIN: r_cfg.short_min_us <= i_data;
                CFG_SHORT_MAX: r_cfg.short_max_us <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/rfpcr_gap_class.sv
module rfpcr_gap_class
    import rfpcr_pkg::*;
(
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_prev,
    input  t_cfg              i_cfg,
    output t_gap              o_class
);

    logic [TIME_W-1:0] gap;
    logic              backward;
    logic              gap_big;
    logic [WIN_W-1:0]  gap_lo;

    // anything with bits above the window width beats every 16-bit bound
    function automatic logic in_win(input logic big, input logic [WIN_W-1:0] g,
                                    input logic [WIN_W-1:0] lo,
                                    input logic [WIN_W-1:0] hi);
        return !big && (g >= lo) && (g < hi);
    endfunction

    assign backward = i_now < i_prev;
    assign gap      = i_now - i_prev;
    assign gap_big  = |gap[TIME_W-1:WIN_W];
    assign gap_lo   = gap[WIN_W-1:0];

    always_comb begin
        if (backward) begin
            o_class = GAP_NONE;
        end else if (gap_big || gap_lo >= i_cfg.sync_min_us) begin
            o_class = GAP_SYNC;
        end else if (in_win(gap_big, gap_lo, i_cfg.start_min_us, i_cfg.start_max_us)) begin
            o_class = GAP_START;
        end else if (in_win(gap_big, gap_lo, i_cfg.long_min_us, i_cfg.long_max_us)) begin
            o_class = GAP_LONG;
        end else if (in_win(gap_big, gap_lo, i_cfg.short_min_us, i_cfg.short_max_us)) begin
            o_class = GAP_SHORT;
        end else begin
            o_class = GAP_NONE;
        end
    end

endmodule

FILE: hdl/rfpcr_frame_dec.sv
module rfpcr_frame_dec
    import rfpcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_emit,
    output t_out_item o_result
);

    logic [TIME_W-1:0]     r_last_time;
    logic [EDGE_IDX_W-1:0] r_edge_idx;
    logic                  r_hdr_ok;
    logic [CODE_BITS-1:0]  r_code;

    logic [EDGE_IDX_W-1:0] n_edge_idx;
    logic                  n_hdr_ok;
    logic [CODE_BITS-1:0]  n_code;

    t_gap                  cls;
    logic                  is_sync;
    logic                  frame_ok;
    logic [EDGE_IDX_W-1:0] k;
    logic                  k_hdr_ok;
    logic [CODE_BITS-1:0]  k_code;
    logic [EDGE_IDX_W-3:0] bit_no;
    logic [EDGE_IDX_W-3:0] pos;

    rfpcr_gap_class u_gap_class (
        .i_now   (i_item.edge_time),
        .i_prev  (r_last_time),
        .i_cfg   (i_cfg),
        .o_class (cls)
    );

    assign is_sync  = cls == GAP_SYNC;
    assign frame_ok = r_hdr_ok && (r_edge_idx >= EDGE_IDX_W'(HDR_EDGES));

    assign o_emit              = is_sync;
    assign o_result.frame_ok   = frame_ok;
    assign o_result.frame_code = frame_ok ? 32'(r_code) : '0;

    // a sync edge closes the frame and becomes edge 0 of the next one
    assign k        = is_sync ? '0 : r_edge_idx;
    assign k_hdr_ok = is_sync ? 1'b1 : r_hdr_ok;
    assign k_code   = is_sync ? '0 : r_code;
    assign bit_no   = k[EDGE_IDX_W-1:2];
    assign pos      = (EDGE_IDX_W-2)'(CODE_BITS) - bit_no;

    always_comb begin
        n_hdr_ok = k_hdr_ok;
        n_code   = k_code;
        if (k < EDGE_IDX_W'(HDR_EDGES)) begin
            if (cls != header_class(k[1:0]) || i_item.line_level != HDR_LEVELS[k[1:0]]) begin
                n_hdr_ok = 1'b0;
            end
        end else if (k[1:0] == 2'b00 && bit_no <= (EDGE_IDX_W-2)'(CODE_BITS)) begin
            if (cls == GAP_LONG) begin
                n_code[pos[POS_W-1:0]] = 1'b1;
            end
        end
        n_edge_idx = (k < EDGE_IDX_W'(EDGE_CAP)) ? k + 1'b1 : k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_edge_idx  <= '0;
            r_hdr_ok    <= 1'b1;
            r_code      <= '0;
        end else if (i_step) begin
            r_last_time <= i_item.edge_time;
            r_edge_idx  <= n_edge_idx;
            r_hdr_ok    <= n_hdr_ok;
            r_code      <= n_code;
        end
    end

endmodule

FILE: hdl/rf_pulse_code_receiver_core.sv
// Decoder for on-off-keyed remote switch codes. Each input transfer is one
// line edge (63-bit microsecond timestamp, pin level after the edge); the gap
// to the previous edge is sorted into sync, start, long or short windows set
// through the configuration port, which is only to be written while no edge
// is in flight. Every sync edge closes the current frame and yields one
// result transfer: frame_ok plus the 32-bit code, taken MSB first after the
// sync/short/start/short header from edges 4 to 128 (the sync is edge 0),
// at indices divisible by 4 (zero if the frame failed). An edge is decoded
// while it sits in the input register, and a sync edge's result is loaded
// into the result register as that edge leaves it, so one edge per cycle is
// taken while no result is held; the single result register is the only
// point of back-pressure, and a held result stalls further edges.
module rf_pulse_code_receiver_core
    import rfpcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data
);

    logic      r_a_valid;
    t_in_item  r_a_item;
    logic      r_out_valid;
    t_out_item r_out;

    t_cfg      cfg;
    logic      advance;
    logic      emit;
    t_out_item result;

    assign o_cfg_ready = 1'b1;

    rfpcr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance    = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || advance;

    rfpcr_frame_dec u_frame_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_a_item),
        .i_cfg    (cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a_item <= i_in;
        end
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fail_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_ok |-> r_out.frame_code == '0)
        else $error("failed frame carries a non-zero code");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_a_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a held result");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_a_valid)
        else $error("accepted edge lost from input register");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && emit))
        else $error("result appeared without a decoded sync edge");

endmodule
